// ===== rtl/grid_astar_path_search_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH

// Implication into the next cycle, masked while reset is low.
`define GAPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication, masked while reset is low.
`define GAPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked through reset too.
`define GAPS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gaps_pkg.sv =====
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types, codes and helpers of the grid A* path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int COORD_W      = 6;
    localparam int ACT_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 12;
    localparam int COST_W       = 16;
    localparam int DIR_W        = 3;
    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int OCT_W        = 8;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 24;

    localparam logic [CFG_W-1:0] GRID_SIDE_RST = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;
    // spare code: changes nothing, answered with a range status
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PATH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

    localparam logic [COST_W-1:0] COST_STRAIGHT = 16'd10;
    localparam logic [COST_W-1:0] COST_DIAGONAL = 16'd14;

    // Direction order: (-1,-1),(-1,0),(-1,1),(0,-1),(0,1),(1,-1),(1,0),(1,1)
    localparam logic [7:0] DIR_DIAG = 8'b1010_0101;
    localparam logic [7:0] DX_NEG   = 8'b0000_0111;
    localparam logic [7:0] DX_POS   = 8'b1110_0000;
    localparam logic [7:0] DY_NEG   = 8'b0010_1001;
    localparam logic [7:0] DY_POS   = 8'b1001_0100;
    // Orthogonal cells passed by a diagonal move
    localparam logic [DIR_W-1:0] ORTH_A [8] = '{3'd1, 3'd0, 3'd1, 3'd0, 3'd0, 3'd6, 3'd0, 3'd6};
    localparam logic [DIR_W-1:0] ORTH_B [8] = '{3'd3, 3'd0, 3'd4, 3'd0, 3'd0, 3'd3, 3'd0, 3'd4};

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
        logic               walkable;
        logic [LEN_W-1:0]   path_index;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    path_length;
        logic [COORD_W-1:0]  step_x;
        logic [COORD_W-1:0]  step_y;
    } result_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WR_RD, S_WR_WB, S_RD_RD, S_RD_DATA,
        S_GOAL_RD, S_GOAL_CHK, S_PROBE, S_GSEL, S_SWEEP, S_SEED,
        S_SCAN, S_SCAN_END, S_PICK, S_EXP_RD, S_EXP_UPD,
        S_TR_RD, S_TR_STEP, S_WP_RD, S_WP_WR, S_RESP
    } ctrl_state_t;

    // Octile distance: 14 per diagonal step, 10 per straight step
    function automatic logic [COST_W-1:0] octile(input logic [OCT_W-1:0] ax,
                                                  input logic [OCT_W-1:0] ay,
                                                  input logic [OCT_W-1:0] bx,
                                                  input logic [OCT_W-1:0] by);
        logic [OCT_W-1:0] dx;
        logic [OCT_W-1:0] dy;
        logic [OCT_W-1:0] mx;
        logic [OCT_W-1:0] mn;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        mx = (dx > dy) ? dx : dy;
        mn = (dx > dy) ? dy : dx;
        return (COST_W'(mx) * COST_W'(10)) + (COST_W'(mn) << 2);
    endfunction

endpackage

// ===== rtl/grid_astar_path_search_top.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_top
// Grid A* path search with a walkability map and a stored path.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel carries one request; s_tuser is the action (write map cell,
//    search, read path step). m_ channel returns exactly one result per
//    request; m_tuser is the status.
//  - cfg_wr_en/cfg_index/cfg_wdata set grid width (index 0) and height
//    (index 1); write them only while no request is in flight.
//  - Search: node memory clear (MAX_SIDE squared entries), then per
//    expanded cell one full open-list scan of width*height cells over the
//    node memory read port plus neighbour work; the path is traced and
//    stored step by step.
//  - Reset: the walk map (all walkable) and node memory are cleared in one
//    pass; s_tready stays low until it ends.
//  - One request at a time. A result waits in the output register while
//    m_tready is low; the next request is already taken meanwhile and its
//    result waits until the register frees.
module grid_astar_path_search_top #(
    parameter int MAX_SIDE = gaps_pkg::MAX_SIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] cell_x, [11:6] cell_y, [17:12] goal_x, [23:18] goal_y,
    // [24] walkable, [36:25] path_index, [39:37] zero
    input  logic [gaps_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [gaps_pkg::ACT_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] path_length, [17:12] step_x, [23:18] step_y
    output logic [gaps_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [gaps_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [gaps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gaps_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int AW     = 2 * CW;
    localparam int SW     = CW + 1;
    localparam int NW     = 2 + gaps_pkg::DIR_W + gaps_pkg::COST_W;
    localparam int CFG_W  = gaps_pkg::CFG_W;
    localparam int TW     = (SW > CFG_W) ? SW : CFG_W;
    localparam int DEPTH  = 1 << AW;

    // Grid size registers
    logic [CFG_W-1:0] grid_w_reg, grid_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= gaps_pkg::GRID_SIDE_RST;
            grid_h_reg <= gaps_pkg::GRID_SIDE_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == gaps_pkg::REG_GRID_WIDTH) begin
                grid_w_reg <= cfg_wdata;
            end
            if (cfg_index == gaps_pkg::REG_GRID_HEIGHT) begin
                grid_h_reg <= cfg_wdata;
            end
        end
    end

    // Zero acts as one, anything above MAX_SIDE as MAX_SIDE
    function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [TW-1:0] e;
        e = TW'(v);
        if (e == '0) return SW'(1);
        if (e > TW'(MAX_SIDE)) return SW'(MAX_SIDE);
        return SW'(e);
    endfunction

    logic [SW-1:0] side_w, side_h;
    assign side_w = clamp_side(grid_w_reg);
    assign side_h = clamp_side(grid_h_reg);

    // Request unpacking
    gaps_pkg::item_t item;
    assign item.action     = s_tuser;
    assign item.cell_x     = s_tdata[5:0];
    assign item.cell_y     = s_tdata[11:6];
    assign item.goal_x     = s_tdata[17:12];
    assign item.goal_y     = s_tdata[23:18];
    assign item.walkable   = s_tdata[24];
    assign item.path_index = s_tdata[36:25];

    gaps_pkg::result_t res;
    logic              res_valid, res_ready;

    logic          wm_we, nd_we;
    logic [AW-1:0] wm_waddr, wm_raddr, nd_waddr, nd_raddr;
    logic [AW:0]   wm_wdata, wm_rdata;
    logic [NW-1:0] nd_wdata, nd_rdata;

    gaps_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .side_w    (side_w),
        .side_h    (side_h),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wm_we     (wm_we),
        .wm_waddr  (wm_waddr),
        .wm_wdata  (wm_wdata),
        .wm_raddr  (wm_raddr),
        .wm_rdata  (wm_rdata),
        .nd_we     (nd_we),
        .nd_waddr  (nd_waddr),
        .nd_wdata  (nd_wdata),
        .nd_raddr  (nd_raddr),
        .nd_rdata  (nd_rdata)
    );

    // Walk map bit plus stored path cell share one word
    gaps_ram #(
        .WIDTH (AW + 1),
        .DEPTH (DEPTH)
    ) u_walk_ram (
        .aclk  (aclk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (wm_wdata),
        .raddr (wm_raddr),
        .rdata (wm_rdata)
    );

    // Per-cell search node: open, closed, came_from, cost
    gaps_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (nd_we),
        .waddr (nd_waddr),
        .wdata (nd_wdata),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    // Output register
    logic                                 m_tvalid_reg;
    logic [gaps_pkg::M_TDATA_W-1:0]       m_tdata_reg;
    logic [gaps_pkg::STATUS_W-1:0]        m_tuser_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= {res.step_y, res.step_x, res.path_length};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/gaps_ram.sv =====
// ----------------------------------------------------------------------------
// gaps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gaps_ctrl.sv =====
// ----------------------------------------------------------------------------
// gaps_ctrl
// Sequencer: map writes, path reads, and the A* search over the node memory.
// ----------------------------------------------------------------------------
module gaps_ctrl #(
    parameter int MAX_SIDE = gaps_pkg::MAX_SIDE_DEF,
    parameter int CW       = $clog2(MAX_SIDE),
    parameter int AW       = 2 * CW,
    parameter int NW       = 2 + gaps_pkg::DIR_W + gaps_pkg::COST_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CW:0]           side_w,
    input  logic [CW:0]           side_h,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gaps_pkg::item_t       in_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output gaps_pkg::result_t     res,
    // walk map / path store memory: {walk, path cell}
    output logic                  wm_we,
    output logic [AW-1:0]         wm_waddr,
    output logic [AW:0]           wm_wdata,
    output logic [AW-1:0]         wm_raddr,
    input  logic [AW:0]           wm_rdata,
    // node memory: {open, closed, dir, cost}
    output logic                  nd_we,
    output logic [AW-1:0]         nd_waddr,
    output logic [NW-1:0]         nd_wdata,
    output logic [AW-1:0]         nd_raddr,
    input  logic [NW-1:0]         nd_rdata
);

    localparam int SW     = CW + 1;
    localparam int COST_W = gaps_pkg::COST_W;
    localparam int DIR_W  = gaps_pkg::DIR_W;
    localparam int LEN_W  = gaps_pkg::LEN_W;
    localparam int CRD_W  = gaps_pkg::COORD_W;
    localparam int OCT_W  = gaps_pkg::OCT_W;
    localparam int CMPW   = (SW > CRD_W + 1) ? SW : CRD_W + 1;
    localparam int LCW    = (AW > LEN_W) ? AW : LEN_W;
    localparam int FW     = COST_W + 1;

    gaps_pkg::ctrl_state_t state_reg, state_next;

    logic [CW-1:0]     sx_reg, sy_reg, gx_reg, gy_reg, cx_reg, cy_reg, px_reg, py_reg;
    logic [CW-1:0]     sx_next, sy_next, gx_next, gy_next, cx_next, cy_next, px_next, py_next;
    logic              walk_bit_reg, walk_bit_next;
    logic [LEN_W-1:0]  pidx_reg, pidx_next;
    logic [AW-1:0]     addr_cnt_reg, addr_cnt_next;
    logic [3:0]        dir_cnt_reg, dir_cnt_next;
    logic [7:0]        nb_reg, nb_next;
    logic              pend_reg, pend_next, pend_in_reg, pend_in_next;
    logic [DIR_W-1:0]  pend_d_reg, pend_d_next;
    logic              probe_goal_reg, probe_goal_next;
    logic              have_reg, have_next;
    logic [FW-1:0]     bf_reg, bf_next;
    logic [COST_W-1:0] bh_reg, bh_next;
    logic [AW-1:0]     best_addr_reg, best_addr_next;
    logic [COST_W-1:0] best_cost_reg, best_cost_next;
    logic [DIR_W-1:0]  best_dir_reg, best_dir_next;
    logic [CW-1:0]     scan_x_reg, scan_y_reg, scan_x_next, scan_y_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_addr_reg, s1_addr_next;
    logic [COST_W-1:0] s1_h_reg, s1_h_next;
    logic [COST_W-1:0] cur_cost_reg, cur_cost_next;
    logic [AW-1:0]     len_reg, len_next, k_reg, k_next, stored_len_reg, stored_len_next;
    logic [gaps_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]     step_x_reg, step_y_reg, step_x_next, step_y_next;

    // Decoded node word
    logic              nd_open, nd_closed;
    logic [DIR_W-1:0]  nd_dir;
    logic [COST_W-1:0] nd_cost;
    assign nd_open   = nd_rdata[NW-1];
    assign nd_closed = nd_rdata[NW-2];
    assign nd_dir    = nd_rdata[COST_W +: DIR_W];
    assign nd_cost   = nd_rdata[COST_W-1:0];

    // Request range checks on the port-wide coordinates
    logic cell_ok, goal_ok, pidx_ok;
    assign cell_ok = (CMPW'(in_item.cell_x) < CMPW'(side_w))
                  && (CMPW'(in_item.cell_y) < CMPW'(side_h));
    assign goal_ok = (CMPW'(in_item.goal_x) < CMPW'(side_w))
                  && (CMPW'(in_item.goal_y) < CMPW'(side_h));
    assign pidx_ok = LCW'(in_item.path_index) < LCW'(stored_len_reg);

    // Neighbour of the current cell in direction dir_cnt
    logic [DIR_W-1:0] d_sel;
    logic [SW-1:0]    nx_w, ny_w;
    logic             nbr_in;
    logic [CW-1:0]    nbr_x, nbr_y;
    logic [AW-1:0]    nbr_addr;
    assign d_sel  = dir_cnt_reg[DIR_W-1:0];
    assign nx_w   = {1'b0, cx_reg} + (gaps_pkg::DX_POS[d_sel] ? SW'(1) :
                                      gaps_pkg::DX_NEG[d_sel] ? {SW{1'b1}} : SW'(0));
    assign ny_w   = {1'b0, cy_reg} + (gaps_pkg::DY_POS[d_sel] ? SW'(1) :
                                      gaps_pkg::DY_NEG[d_sel] ? {SW{1'b1}} : SW'(0));
    assign nbr_in = (nx_w < side_w) && (ny_w < side_h);
    assign nbr_x  = nx_w[CW-1:0];
    assign nbr_y  = ny_w[CW-1:0];
    assign nbr_addr = {nbr_y, nbr_x};

    // Moves allowed by bounds, walkability and the corner rule
    logic [7:0] usable;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            usable[i] = nb_reg[i] && (!gaps_pkg::DIR_DIAG[i]
                        || (nb_reg[gaps_pkg::ORTH_A[i]] && nb_reg[gaps_pkg::ORTH_B[i]]));
        end
    end

    logic [COST_W-1:0] new_cost, gsel_dist, scan_h;
    logic [FW-1:0]     s1_f;
    assign new_cost  = cur_cost_reg + (gaps_pkg::DIR_DIAG[d_sel] ? gaps_pkg::COST_DIAGONAL
                                                                  : gaps_pkg::COST_STRAIGHT);
    assign gsel_dist = gaps_pkg::octile(OCT_W'(nbr_x), OCT_W'(nbr_y),
                                        OCT_W'(sx_reg), OCT_W'(sy_reg));
    assign scan_h    = gaps_pkg::octile(OCT_W'(scan_x_reg), OCT_W'(scan_y_reg),
                                        OCT_W'(gx_reg), OCT_W'(gy_reg));
    assign s1_f      = FW'(nd_cost) + FW'(s1_h_reg);

    // One step back along came_from
    logic [CW-1:0] back_x, back_y;
    assign back_x = px_reg + (gaps_pkg::DX_NEG[nd_dir] ? CW'(1) :
                              gaps_pkg::DX_POS[nd_dir] ? {CW{1'b1}} : CW'(0));
    assign back_y = py_reg + (gaps_pkg::DY_NEG[nd_dir] ? CW'(1) :
                              gaps_pkg::DY_POS[nd_dir] ? {CW{1'b1}} : CW'(0));

    logic at_start, scan_last_x, scan_last_y, best_is_goal;
    assign at_start     = (px_reg == sx_reg) && (py_reg == sy_reg);
    assign scan_last_x  = {1'b0, scan_x_reg} == side_w - SW'(1);
    assign scan_last_y  = {1'b0, scan_y_reg} == side_h - SW'(1);
    assign best_is_goal = best_addr_reg == {gy_reg, gx_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gaps_pkg::S_CLEAR:    if (&addr_cnt_reg) state_next = gaps_pkg::S_IDLE;
            gaps_pkg::S_IDLE: begin
                if (in_valid) begin
                    priority case (in_item.action)
                        gaps_pkg::ACT_WRITE:
                            state_next = cell_ok ? gaps_pkg::S_WR_RD : gaps_pkg::S_RESP;
                        gaps_pkg::ACT_SEARCH:
                            state_next = (cell_ok && goal_ok) ? gaps_pkg::S_GOAL_RD
                                                              : gaps_pkg::S_RESP;
                        gaps_pkg::ACT_READ:
                            state_next = pidx_ok ? gaps_pkg::S_RD_RD : gaps_pkg::S_RESP;
                        default: state_next = gaps_pkg::S_RESP;
                    endcase
                end
            end
            gaps_pkg::S_WR_RD:    state_next = gaps_pkg::S_WR_WB;
            gaps_pkg::S_WR_WB:    state_next = gaps_pkg::S_RESP;
            gaps_pkg::S_RD_RD:    state_next = gaps_pkg::S_RD_DATA;
            gaps_pkg::S_RD_DATA:  state_next = gaps_pkg::S_RESP;
            gaps_pkg::S_GOAL_RD:  state_next = gaps_pkg::S_GOAL_CHK;
            gaps_pkg::S_GOAL_CHK: state_next = wm_rdata[AW] ? gaps_pkg::S_SWEEP
                                                            : gaps_pkg::S_PROBE;
            gaps_pkg::S_PROBE: begin
                if (dir_cnt_reg[3]) begin
                    state_next = probe_goal_reg ? gaps_pkg::S_GSEL : gaps_pkg::S_EXP_RD;
                end
            end
            gaps_pkg::S_GSEL: begin
                if (dir_cnt_reg[3]) begin
                    state_next = have_reg ? gaps_pkg::S_SWEEP : gaps_pkg::S_RESP;
                end
            end
            gaps_pkg::S_SWEEP:    if (&addr_cnt_reg) state_next = gaps_pkg::S_SEED;
            gaps_pkg::S_SEED:     state_next = gaps_pkg::S_SCAN;
            gaps_pkg::S_SCAN:     if (scan_last_x && scan_last_y) state_next = gaps_pkg::S_SCAN_END;
            gaps_pkg::S_SCAN_END: state_next = gaps_pkg::S_PICK;
            gaps_pkg::S_PICK: begin
                priority if (!have_reg) state_next = gaps_pkg::S_RESP;
                else if (best_is_goal)  state_next = gaps_pkg::S_TR_RD;
                else                    state_next = gaps_pkg::S_PROBE;
            end
            gaps_pkg::S_EXP_RD: begin
                priority if (dir_cnt_reg[3]) state_next = gaps_pkg::S_SCAN;
                else if (usable[d_sel])      state_next = gaps_pkg::S_EXP_UPD;
                else                         state_next = gaps_pkg::S_EXP_RD;
            end
            gaps_pkg::S_EXP_UPD:  state_next = gaps_pkg::S_EXP_RD;
            gaps_pkg::S_TR_RD:    state_next = at_start ? gaps_pkg::S_WP_RD : gaps_pkg::S_TR_STEP;
            gaps_pkg::S_TR_STEP:  state_next = gaps_pkg::S_TR_RD;
            gaps_pkg::S_WP_RD:    state_next = (k_reg == '0) ? gaps_pkg::S_RESP
                                                             : gaps_pkg::S_WP_WR;
            gaps_pkg::S_WP_WR:    state_next = gaps_pkg::S_WP_RD;
            gaps_pkg::S_RESP:     if (res_ready) state_next = gaps_pkg::S_IDLE;
            default:              state_next = gaps_pkg::S_CLEAR;
        endcase
    end

    // Outputs and memory requests
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        wm_we     = 1'b0;
        wm_waddr  = addr_cnt_reg;
        wm_wdata  = {1'b1, {AW{1'b0}}};
        wm_raddr  = {gy_reg, gx_reg};
        nd_we     = 1'b0;
        nd_waddr  = addr_cnt_reg;
        nd_wdata  = '0;
        nd_raddr  = {scan_y_reg, scan_x_reg};
        unique case (state_reg)
            gaps_pkg::S_CLEAR: begin
                wm_we = 1'b1;
                nd_we = 1'b1;
            end
            gaps_pkg::S_IDLE:    in_ready = 1'b1;
            gaps_pkg::S_WR_RD:   wm_raddr = {sy_reg, sx_reg};
            gaps_pkg::S_WR_WB: begin
                wm_we    = 1'b1;
                wm_waddr = {sy_reg, sx_reg};
                wm_wdata = {walk_bit_reg, wm_rdata[AW-1:0]};
            end
            gaps_pkg::S_RD_RD:   wm_raddr = AW'(pidx_reg);
            gaps_pkg::S_PROBE:   wm_raddr = nbr_addr;
            gaps_pkg::S_SWEEP:   nd_we = 1'b1;
            gaps_pkg::S_SEED: begin
                nd_we    = 1'b1;
                nd_waddr = {sy_reg, sx_reg};
                nd_wdata = {1'b1, 1'b0, {DIR_W{1'b0}}, {COST_W{1'b0}}};
            end
            gaps_pkg::S_PICK: begin
                nd_we    = have_reg;
                nd_waddr = best_addr_reg;
                nd_wdata = {1'b0, 1'b1, best_dir_reg, best_cost_reg};
            end
            gaps_pkg::S_EXP_RD:  nd_raddr = nbr_addr;
            gaps_pkg::S_EXP_UPD: begin
                nd_waddr = nbr_addr;
                nd_wdata = {1'b1, 1'b0, d_sel, new_cost};
                nd_we    = !nd_closed && (!nd_open || new_cost < nd_cost);
            end
            gaps_pkg::S_TR_RD:   nd_raddr = {py_reg, px_reg};
            gaps_pkg::S_WP_RD: begin
                nd_raddr = {py_reg, px_reg};
                wm_raddr = k_reg - AW'(1);
            end
            gaps_pkg::S_WP_WR: begin
                wm_we    = 1'b1;
                wm_waddr = k_reg - AW'(1);
                wm_wdata = {wm_rdata[AW], py_reg, px_reg};
            end
            gaps_pkg::S_RESP:    res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res.status      = status_reg;
    assign res.path_length = LEN_W'(stored_len_reg);
    assign res.step_x      = CRD_W'(step_x_reg);
    assign res.step_y      = CRD_W'(step_y_reg);

    // Datapath
    always_comb begin
        sx_next = sx_reg;  sy_next = sy_reg;  gx_next = gx_reg;  gy_next = gy_reg;
        cx_next = cx_reg;  cy_next = cy_reg;  px_next = px_reg;  py_next = py_reg;
        walk_bit_next   = walk_bit_reg;
        pidx_next       = pidx_reg;
        addr_cnt_next   = addr_cnt_reg;
        dir_cnt_next    = dir_cnt_reg;
        nb_next         = nb_reg;
        pend_next       = 1'b0;
        pend_in_next    = pend_in_reg;
        pend_d_next     = pend_d_reg;
        probe_goal_next = probe_goal_reg;
        have_next       = have_reg;
        bf_next         = bf_reg;
        bh_next         = bh_reg;
        best_addr_next  = best_addr_reg;
        best_cost_next  = best_cost_reg;
        best_dir_next   = best_dir_reg;
        scan_x_next     = scan_x_reg;
        scan_y_next     = scan_y_reg;
        s1_valid_next   = 1'b0;
        s1_addr_next    = s1_addr_reg;
        s1_h_next       = s1_h_reg;
        cur_cost_next   = cur_cost_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        stored_len_next = stored_len_reg;
        status_next     = status_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;

        unique case (state_reg)
            gaps_pkg::S_CLEAR:  addr_cnt_next = addr_cnt_reg + AW'(1);
            gaps_pkg::S_IDLE: begin
                sx_next       = CW'(in_item.cell_x);
                sy_next       = CW'(in_item.cell_y);
                gx_next       = CW'(in_item.goal_x);
                gy_next       = CW'(in_item.goal_y);
                walk_bit_next = in_item.walkable;
                pidx_next     = in_item.path_index;
                step_x_next   = '0;
                step_y_next   = '0;
                status_next   = gaps_pkg::ST_RANGE;
                addr_cnt_next = '0;
                if (in_valid && in_item.action == gaps_pkg::ACT_SEARCH) begin
                    stored_len_next = '0;
                end
            end
            gaps_pkg::S_WR_WB:  status_next = gaps_pkg::ST_DONE;
            gaps_pkg::S_RD_DATA: begin
                status_next = gaps_pkg::ST_DONE;
                step_x_next = wm_rdata[CW-1:0];
                step_y_next = wm_rdata[AW-1:CW];
            end
            gaps_pkg::S_GOAL_CHK: begin
                cx_next         = gx_reg;
                cy_next         = gy_reg;
                dir_cnt_next    = '0;
                probe_goal_next = 1'b1;
            end
            gaps_pkg::S_PROBE: begin
                if (pend_reg) begin
                    nb_next[pend_d_reg] = pend_in_reg && wm_rdata[AW];
                end
                if (!dir_cnt_reg[3]) begin
                    pend_next    = 1'b1;
                    pend_d_next  = d_sel;
                    pend_in_next = nbr_in;
                    dir_cnt_next = dir_cnt_reg + 4'd1;
                end else begin
                    dir_cnt_next = '0;
                    have_next    = 1'b0;
                end
            end
            gaps_pkg::S_GSEL: begin
                if (!dir_cnt_reg[3]) begin
                    dir_cnt_next = dir_cnt_reg + 4'd1;
                    if (usable[d_sel] && (!have_reg || gsel_dist < bh_reg)) begin
                        have_next = 1'b1;
                        bh_next   = gsel_dist;
                        px_next   = nbr_x;
                        py_next   = nbr_y;
                    end
                end else if (have_reg) begin
                    gx_next = px_reg;
                    gy_next = py_reg;
                end else begin
                    status_next = gaps_pkg::ST_NO_PATH;
                end
            end
            gaps_pkg::S_SWEEP:  addr_cnt_next = addr_cnt_reg + AW'(1);
            gaps_pkg::S_SEED: begin
                scan_x_next = '0;
                scan_y_next = '0;
                have_next   = 1'b0;
            end
            gaps_pkg::S_SCAN, gaps_pkg::S_SCAN_END: begin
                if (state_reg == gaps_pkg::S_SCAN) begin
                    s1_valid_next = 1'b1;
                    s1_addr_next  = {scan_y_reg, scan_x_reg};
                    s1_h_next     = scan_h;
                    if (scan_last_x) begin
                        scan_x_next = '0;
                        scan_y_next = scan_last_y ? '0 : scan_y_reg + CW'(1);
                    end else begin
                        scan_x_next = scan_x_reg + CW'(1);
                    end
                end
                if (s1_valid_reg && nd_open && (!have_reg || s1_f < bf_reg
                    || (s1_f == bf_reg && s1_h_reg < bh_reg))) begin
                    have_next      = 1'b1;
                    bf_next        = s1_f;
                    bh_next        = s1_h_reg;
                    best_addr_next = s1_addr_reg;
                    best_cost_next = nd_cost;
                    best_dir_next  = nd_dir;
                end
            end
            gaps_pkg::S_PICK: begin
                cx_next         = best_addr_reg[CW-1:0];
                cy_next         = best_addr_reg[AW-1:CW];
                cur_cost_next   = best_cost_reg;
                dir_cnt_next    = '0;
                probe_goal_next = 1'b0;
                px_next         = gx_reg;
                py_next         = gy_reg;
                len_next        = '0;
                if (!have_reg) status_next = gaps_pkg::ST_NO_PATH;
            end
            gaps_pkg::S_EXP_RD: begin
                if (dir_cnt_reg[3]) begin
                    scan_x_next = '0;
                    scan_y_next = '0;
                    have_next   = 1'b0;
                end else if (!usable[d_sel]) begin
                    dir_cnt_next = dir_cnt_reg + 4'd1;
                end
            end
            gaps_pkg::S_EXP_UPD: dir_cnt_next = dir_cnt_reg + 4'd1;
            gaps_pkg::S_TR_RD: begin
                if (at_start) begin
                    k_next  = len_reg;
                    px_next = gx_reg;
                    py_next = gy_reg;
                end
            end
            gaps_pkg::S_TR_STEP: begin
                px_next  = back_x;
                py_next  = back_y;
                len_next = len_reg + AW'(1);
            end
            gaps_pkg::S_WP_RD: begin
                if (k_reg == '0) begin
                    stored_len_next = len_reg;
                    status_next     = gaps_pkg::ST_FOUND;
                end
            end
            gaps_pkg::S_WP_WR: begin
                px_next = back_x;
                py_next = back_y;
                k_next  = k_reg - AW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gaps_pkg::S_CLEAR;
            addr_cnt_reg   <= '0;
            stored_len_reg <= '0;
            pend_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            addr_cnt_reg   <= addr_cnt_next;
            stored_len_reg <= stored_len_next;
            pend_reg       <= pend_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sx_reg <= sx_next;  sy_reg <= sy_next;  gx_reg <= gx_next;  gy_reg <= gy_next;
        cx_reg <= cx_next;  cy_reg <= cy_next;  px_reg <= px_next;  py_reg <= py_next;
        walk_bit_reg   <= walk_bit_next;
        pidx_reg       <= pidx_next;
        dir_cnt_reg    <= dir_cnt_next;
        nb_reg         <= nb_next;
        pend_in_reg    <= pend_in_next;
        pend_d_reg     <= pend_d_next;
        probe_goal_reg <= probe_goal_next;
        have_reg       <= have_next;
        bf_reg         <= bf_next;
        bh_reg         <= bh_next;
        best_addr_reg  <= best_addr_next;
        best_cost_reg  <= best_cost_next;
        best_dir_reg   <= best_dir_next;
        scan_x_reg     <= scan_x_next;
        scan_y_reg     <= scan_y_next;
        s1_addr_reg    <= s1_addr_next;
        s1_h_reg       <= s1_h_next;
        cur_cost_reg   <= cur_cost_next;
        len_reg        <= len_next;
        k_reg          <= k_next;
        status_reg     <= status_next;
        step_x_reg     <= step_x_next;
        step_y_reg     <= step_y_next;
    end

endmodule

// ===== rtl/gaps_checker.sv =====
// ----------------------------------------------------------------------------
// gaps_checker
// Port-level checks of the grid A* path search block.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_top_macros.svh"

module gaps_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gaps_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [gaps_pkg::STATUS_W-1:0]  m_tuser
);

    // reset starts the clearing pass: nothing taken, nothing shown
    `GAPS_ASSERT_ALWAYS_NEXT(a_reset_quiet, aclk, !aresetn, !s_tready && !m_tvalid, "busy after reset")

    // one request at a time
    `GAPS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second request taken")

    // step fields only carry data on a successful read
    `GAPS_ASSERT_SAME(a_step_zero, aclk, aresetn, m_tvalid && m_tuser != gaps_pkg::ST_DONE, m_tdata[23:12] == 12'd0, "step set")

    // stalled result holds
    `GAPS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result dropped")

endmodule

bind grid_astar_path_search_top gaps_checker u_checker (.*);

// ===== tb/sv/tb_grid_astar_path_search_top.sv =====
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search_top
// Self-checking bench for the grid A* path search block.
// Map writes, searches and path reads are streamed through the s_ channel.
// A behavioral route planner predicts every result; the m_ channel output is
// checked field by field in order. The grid size is reprogrammed between
// phases, and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grid_astar_path_search_top;
    import gaps_pkg::*;

    localparam int SIDE       = 64;
    localparam int CELLS      = SIDE * SIDE;
    localparam int RUN_LIMIT  = 8_000_000;   // cycles

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    item_t   cur_req = '0;
    item_t   req_q[$];          // requests waiting to be driven
    result_t result_q[$];       // predicted results, oldest first
    int      errors = 0;
    int      cycles = 0;
    int      tx_idle_pct = 0;   // sender gap chance per cycle
    int      rx_stall_pct = 0;  // receiver stall chance per cycle

    // s_tdata: [5:0] cell_x, [11:6] cell_y, [17:12] goal_x, [23:18] goal_y,
    // [24] walkable, [36:25] path_index, [39:37] zero
    assign s_tdata = {3'b000, cur_req.path_index, cur_req.walkable, cur_req.goal_y,
                      cur_req.goal_x, cur_req.cell_y, cur_req.cell_x};
    assign s_tuser = cur_req.action;

    grid_astar_path_search_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Route planner: walk map, node costs and stored path of the block
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg = GRID_SIDE_RST;
    logic [CFG_W-1:0] height_reg = GRID_SIDE_RST;
    bit               walk_ok   [CELLS];
    int               g_cost    [CELLS];
    int               parent_dir[CELLS];
    bit               in_open   [CELLS];
    bit               in_closed [CELLS];
    int               route_x   [CELLS];
    int               route_y   [CELLS];
    int               route_len = 0;

    // Direction order: (-1,-1),(-1,0),(-1,1),(0,-1),(0,1),(1,-1),(1,0),(1,1)
    int step_dx[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int step_dy[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    initial begin
        foreach (walk_ok[i]) walk_ok[i] = 1'b1;
    end

    // A register of 0 behaves as 1, anything above 64 as 64.
    function automatic int eff_side(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > SIDE) return SIDE;
        return int'(r);
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < eff_side(width_reg) && y < eff_side(height_reg);
    endfunction

    function automatic bit open_at(int x, int y);
        return on_grid(x, y) && walk_ok[y * SIDE + x];
    endfunction

    function automatic int octile_dist(int ax, int ay, int bx, int by);
        int dx, dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return (dx > dy) ? 14 * dy + 10 * (dx - dy) : 14 * dx + 10 * (dy - dx);
    endfunction

    // Bounds plus no corner cutting past a blocked orthogonal cell
    function automatic bit move_ok(int x, int y, int d);
        int nx, ny;
        nx = x + step_dx[d];
        ny = y + step_dy[d];
        if (!on_grid(nx, ny)) return 1'b0;
        if (step_dx[d] != 0 && step_dy[d] != 0)
            if (!open_at(nx, y) || !open_at(x, ny)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [STATUS_W-1:0] plan_route(int sx, int sy, int gx, int gy);
        bit have;
        int best, bx, by, bf, bh, cx, cy, c, n, nx, ny, px, py, len, hv, fv, cost, d;
        route_len = 0;
        if (!on_grid(sx, sy) || !on_grid(gx, gy)) return ST_RANGE;

        // Blocked goal: retarget to the usable neighbor nearest the start
        if (!walk_ok[gy * SIDE + gx]) begin
            have = 1'b0;
            best = 0; bx = 0; by = 0;
            for (d = 0; d < 8; d++) begin
                nx = gx + step_dx[d];
                ny = gy + step_dy[d];
                if (!move_ok(gx, gy, d) || !walk_ok[ny * SIDE + nx]) continue;
                if (!have || octile_dist(nx, ny, sx, sy) < best) begin
                    have = 1'b1;
                    best = octile_dist(nx, ny, sx, sy);
                    bx = nx; by = ny;
                end
            end
            if (!have) return ST_NO_PATH;
            gx = bx; gy = by;
        end

        foreach (in_open[i]) begin
            in_open[i] = 1'b0;
            in_closed[i] = 1'b0;
        end
        g_cost[sy * SIDE + sx] = 0;
        in_open[sy * SIDE + sx] = 1'b1;

        forever begin
            // Pick: smallest f, then smallest h, then lowest row-major index
            have = 1'b0;
            bf = 0; bh = 0; cx = 0; cy = 0;
            for (int y = 0; y < eff_side(height_reg); y++)
                for (int x = 0; x < eff_side(width_reg); x++) begin
                    if (!in_open[y * SIDE + x]) continue;
                    hv = octile_dist(x, y, gx, gy);
                    fv = g_cost[y * SIDE + x] + hv;
                    if (!have || fv < bf || (fv == bf && hv < bh)) begin
                        have = 1'b1;
                        bf = fv; bh = hv; cx = x; cy = y;
                    end
                end
            if (!have) return ST_NO_PATH;
            c = cy * SIDE + cx;
            in_open[c] = 1'b0;
            in_closed[c] = 1'b1;

            if (cx == gx && cy == gy) begin
                len = 0;
                px = gx; py = gy;
                while ((px != sx || py != sy) && len < CELLS) begin
                    d = parent_dir[py * SIDE + px];
                    px -= step_dx[d]; py -= step_dy[d];
                    len++;
                end
                px = gx; py = gy;
                for (int k = len; k > 0; k--) begin
                    d = parent_dir[py * SIDE + px];
                    route_x[k - 1] = px;
                    route_y[k - 1] = py;
                    px -= step_dx[d]; py -= step_dy[d];
                end
                route_len = len;
                return ST_FOUND;
            end

            for (d = 0; d < 8; d++) begin
                if (!move_ok(cx, cy, d)) continue;
                nx = cx + step_dx[d];
                ny = cy + step_dy[d];
                n = ny * SIDE + nx;
                if (!walk_ok[n] || in_closed[n]) continue;
                cost = g_cost[c] + octile_dist(cx, cy, nx, ny);
                if (!in_open[n] || cost < g_cost[n]) begin
                    g_cost[n] = cost;
                    parent_dir[n] = d;
                    in_open[n] = 1'b1;
                end
            end
        end
    endfunction

    function automatic result_t predict_result(item_t rq);
        result_t r;
        r = '0;
        r.status = ST_RANGE;
        case (rq.action)
            ACT_WRITE: begin
                if (on_grid(rq.cell_x, rq.cell_y)) begin
                    walk_ok[rq.cell_y * SIDE + rq.cell_x] = rq.walkable;
                    r.status = ST_DONE;
                end
            end
            ACT_SEARCH: r.status = plan_route(rq.cell_x, rq.cell_y, rq.goal_x, rq.goal_y);
            ACT_READ: begin
                if (rq.path_index < route_len) begin
                    r.step_x = COORD_W'(route_x[rq.path_index]);
                    r.step_y = COORD_W'(route_y[rq.path_index]);
                    r.status = ST_DONE;
                end
            end
            default: ;   // unused action code: range status, no change
        endcase
        r.path_length = route_len[LEN_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predicts each accepted request, then presents the next one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (s_tvalid && s_tready)
            result_q = {result_q, predict_result(cur_req)};
        if (aresetn && (!s_tvalid || s_tready)) begin
            if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                cur_req  <= req_q.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, in-order compare against predictions
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got, want;
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        if (m_tvalid && m_tready) begin
            got = '0;
            got.status = m_tuser;
            {got.step_y, got.step_x, got.path_length} = m_tdata;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
            end else begin
                want = result_q.pop_front();
                if (got.status != want.status || got.path_length != want.path_length ||
                    got.step_x != want.step_x || got.step_y != want.step_y) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_req(logic [ACT_W-1:0] act, int cx, int cy, int gx, int gy,
                           int wk, int pidx);
        item_t rq;
        rq.action     = act;
        rq.cell_x     = COORD_W'(cx);
        rq.cell_y     = COORD_W'(cy);
        rq.goal_x     = COORD_W'(gx);
        rq.goal_y     = COORD_W'(gy);
        rq.walkable   = wk[0];
        rq.path_index = LEN_W'(pidx);
        req_q = {req_q, rq};
    endtask

    // Sender holds off until every expected result is back, then a short
    // settle time before the grid registers may change.
    task automatic drain();
        do @(posedge aclk);
        while (req_q.size() != 0 || s_tvalid || result_q.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_grid(int w, int h);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_GRID_WIDTH;
        cfg_wdata <= CFG_W'(w);
        width_reg = CFG_W'(w);
        @(posedge aclk);
        cfg_index <= REG_GRID_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        height_reg = CFG_W'(h);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly on the grid, sometimes anywhere in the 6-bit range
    function automatic int pick_coord(int side);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, side - 1);
    endfunction

    // Mostly write/search/read sequences with random content, the rest noise
    task automatic random_phase(int n_req);
        int w, h, sent;
        w = eff_side(width_reg);
        h = eff_side(height_reg);
        sent = 0;
        while (sent < n_req) begin
            if ($urandom_range(0, 99) < 80) begin
                repeat ($urandom_range(0, 3)) begin
                    add_req(ACT_WRITE, pick_coord(w), pick_coord(h), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 99) < 55, $urandom);
                    sent++;
                end
                add_req(ACT_SEARCH, pick_coord(w), pick_coord(h), pick_coord(w),
                        pick_coord(h), $urandom, $urandom);
                sent++;
                repeat ($urandom_range(1, 2)) begin
                    add_req(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                        : $urandom_range(0, 12));
                    sent++;
                end
            end else begin
                add_req(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                        $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom, $urandom_range(0, 4095));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Full 64x64 grid after reset
        add_req(ACT_SEARCH, 5, 5, 5, 5, 0, 0);          // start equals goal
        add_req(ACT_SEARCH, 0, 0, 3, 2, 1, 0);          // short open-field route
        add_req(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_req(ACT_READ, 0, 0, 0, 0, 0, 2);            // last step, the goal
        add_req(ACT_READ, 0, 0, 0, 0, 0, 3);            // one past the end
        add_req(ACT_READ, 63, 63, 63, 63, 1, 4095);
        add_req(ACT_WRITE, 63, 63, 0, 0, 0, 0);
        add_req(ACT_WRITE, 0, 0, 63, 63, 1, 4095);
        add_req(ACT_SEARCH, 60, 60, 63, 63, 0, 0);      // blocked goal, retargeted
        add_req(ACT_READ, 0, 0, 0, 0, 0, 1);
        add_req(ACT_UNUSED, 63, 63, 63, 63, 1, 4095);
        drain();

        // Small 5x4 grid: range errors, a wall, a single gap
        set_grid(5, 4);
        add_req(ACT_WRITE, 5, 0, 0, 0, 0, 0);           // column out of range
        add_req(ACT_WRITE, 0, 4, 0, 0, 0, 0);           // row out of range
        add_req(ACT_SEARCH, 0, 0, 6, 1, 0, 0);          // goal outside the grid
        add_req(ACT_SEARCH, 7, 0, 1, 1, 0, 0);          // start outside the grid
        add_req(ACT_WRITE, 2, 0, 0, 0, 0, 0);
        add_req(ACT_WRITE, 2, 1, 0, 0, 0, 0);
        add_req(ACT_WRITE, 2, 2, 0, 0, 0, 0);
        add_req(ACT_WRITE, 2, 3, 0, 0, 0, 0);
        add_req(ACT_SEARCH, 0, 0, 4, 0, 0, 0);          // full wall: no path
        add_req(ACT_SEARCH, 0, 0, 2, 1, 0, 0);          // blocked goal, other side
        add_req(ACT_WRITE, 2, 2, 0, 0, 1, 0);           // gap: corners can't be cut
        add_req(ACT_SEARCH, 0, 0, 4, 0, 0, 0);
        add_req(ACT_READ, 0, 0, 0, 0, 0, 1);
        drain();

        // Random phases, one idle pattern each
        set_grid(8, 8);
        random_phase(20);
        drain();

        set_grid(0, 127);                               // acts as 1 x 64
        tx_idle_pct = 76;
        random_phase(20);
        drain();

        set_grid(7, 6);
        tx_idle_pct = 0;
        rx_stall_pct = 76;
        random_phase(20);
        drain();

        set_grid(127, 1);                               // acts as 64 x 1
        tx_idle_pct = 32;
        rx_stall_pct = 32;
        random_phase(20);
        drain();

        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
